>>> sv/lbe_pkg.sv
package lbe_pkg;

	localparam int LED_COUNT_DEF = 16;
	localparam int COLOR_W       = 24;
	localparam int TIME_W        = 8;
	localparam int CFG_IDX_W     = 1;

	localparam logic [7:0]         CODE_ZERO_RST = 8'hFC;
	localparam logic [7:0]         CODE_ONE_RST  = 8'hE0;
	localparam logic [COLOR_W-1:0] ON_COLOR_RST  = 24'h0000FF;
	localparam logic [COLOR_W-1:0] OFF_COLOR_RST = 24'h000000;

	localparam logic [CFG_IDX_W-1:0] CFG_CODE_ZERO = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_ONE  = 1'b1;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_FORCE    = 3'd1,
		OP_SET_ON   = 3'd2,
		OP_SET_BOTH = 3'd3,
		OP_PATTERN  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CH_GREEN = 2'd0,
		CH_RED   = 2'd1,
		CH_BLUE  = 2'd2
	} ch_t;

	// command broadcast to every cell
	typedef struct packed {
		op_t                op;
		logic               on_flag;
		logic [COLOR_W-1:0] on_color;
		logic [COLOR_W-1:0] off_color;
		logic [TIME_W-1:0]  on_ticks;
		logic [TIME_W-1:0]  off_ticks;
	} cmd_t;

	// expand one data byte into eight code bytes, bit 7 first
	function automatic logic [63:0] encode_byte(logic [7:0] v, logic [7:0] zero_b,
		logic [7:0] one_b);
		logic [63:0] acc;
		acc = '0;
		for (int j = 0; j < 8; j++) begin
			acc[j*8 +: 8] = v[j] ? one_b : zero_b;
		end
		return acc;
	endfunction

endpackage

>>> sv/lbe_cell.sv
module lbe_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_en,
	input  lbe_pkg::cmd_t                 cmd,
	input  logic                          tick,
	input  logic                          shift,
	input  logic [lbe_pkg::COLOR_W-1:0]   shift_in,
	output logic [lbe_pkg::COLOR_W-1:0]   color_q
);

	logic [lbe_pkg::TIME_W-1:0]  on_time_q;
	logic [lbe_pkg::TIME_W-1:0]  off_time_q;
	logic [lbe_pkg::TIME_W-1:0]  timer_q;
	logic [lbe_pkg::COLOR_W-1:0] on_color_q;
	logic [lbe_pkg::COLOR_W-1:0] off_color_q;

	logic                        lit;
	logic                        blinking;
	logic [lbe_pkg::TIME_W-1:0]  timer_inc;
	logic [lbe_pkg::TIME_W:0]    period;
	logic [lbe_pkg::TIME_W-1:0]  timer_nxt;

	always_comb begin
		blinking  = (on_time_q != '0) && (off_time_q != '0);
		period    = {1'b0, on_time_q} + {1'b0, off_time_q};
		timer_inc = timer_q + 1'b1;
		timer_nxt = ({1'b0, timer_inc} > period) ? '0 : timer_inc;
		if (on_time_q == '0) begin
			lit = 1'b0;
		end else if (off_time_q == '0) begin
			lit = 1'b1;
		end else begin
			lit = timer_q < on_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q   <= '0;
			off_time_q  <= '0;
			timer_q     <= '0;
			on_color_q  <= lbe_pkg::ON_COLOR_RST;
			off_color_q <= lbe_pkg::OFF_COLOR_RST;
		end else if (tick) begin
			if (blinking) begin
				timer_q <= timer_nxt;
			end
		end else if (cmd_en) begin
			case (cmd.op)
				lbe_pkg::OP_FORCE: begin
					on_time_q  <= {{(lbe_pkg::TIME_W-1){1'b0}}, cmd.on_flag};
					off_time_q <= {{(lbe_pkg::TIME_W-1){1'b0}}, ~cmd.on_flag};
				end
				lbe_pkg::OP_SET_ON: begin
					on_color_q <= cmd.on_color;
					on_time_q  <= {{(lbe_pkg::TIME_W-1){1'b0}}, 1'b1};
					off_time_q <= '0;
				end
				lbe_pkg::OP_SET_BOTH: begin
					on_color_q  <= cmd.on_color;
					off_color_q <= cmd.off_color;
				end
				lbe_pkg::OP_PATTERN: begin
					if (on_time_q != cmd.on_ticks || off_time_q != cmd.off_ticks) begin
						on_time_q  <= cmd.on_ticks;
						off_time_q <= cmd.off_ticks;
						timer_q    <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// chosen color, loaded on tick, then passed toward the head of the chain
	always_ff @(posedge clk) begin
		if (tick) begin
			color_q <= lit ? on_color_q : off_color_q;
		end else if (shift) begin
			color_q <= shift_in;
		end
	end

endmodule

>>> sv/lbe_encoder.sv
module lbe_encoder #(
	parameter int LED_COUNT = lbe_pkg::LED_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lbe_pkg::COLOR_W-1:0]   head_color,
	input  logic [7:0]                    code_zero,
	input  logic [7:0]                    code_one,
	input  logic                          out_stall,
	output logic                          busy_q,
	output logic                          shift,
	output logic                          out_valid,
	output logic [3:0]                    out_led,
	output logic [1:0]                    channel,
	output logic [63:0]                   code_bytes,
	output logic                          last
);

	localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	logic [LED_W-1:0]  led_q;
	lbe_pkg::ch_t      chan_q;
	logic              out_valid_q;
	logic [3:0]        out_led_q;
	lbe_pkg::ch_t      channel_q;
	logic [63:0]       code_bytes_q;
	logic              last_q;

	logic              load;
	logic              last_led;
	logic [7:0]        data_byte;
	logic [LED_W+3:0]  led_ext;

	always_comb begin
		load     = busy_q && (!out_valid_q || !out_stall);
		last_led = (led_q == LED_W'(LED_COUNT - 1));
		shift    = load && (chan_q == lbe_pkg::CH_BLUE);
		led_ext  = {4'b0000, led_q};
		case (chan_q)
			lbe_pkg::CH_GREEN: data_byte = head_color[15:8];
			lbe_pkg::CH_RED:   data_byte = head_color[23:16];
			lbe_pkg::CH_BLUE:  data_byte = head_color[7:0];
			default:           data_byte = head_color[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			led_q       <= '0;
			chan_q      <= lbe_pkg::CH_GREEN;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				led_q  <= '0;
				chan_q <= lbe_pkg::CH_GREEN;
			end else if (load) begin
				case (chan_q)
					lbe_pkg::CH_GREEN: chan_q <= lbe_pkg::CH_RED;
					lbe_pkg::CH_RED:   chan_q <= lbe_pkg::CH_BLUE;
					default: begin
						chan_q <= lbe_pkg::CH_GREEN;
						if (last_led) begin
							busy_q <= 1'b0;
							led_q  <= '0;
						end else begin
							led_q <= led_q + 1'b1;
						end
					end
				endcase
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_led_q    <= led_ext[3:0];
			channel_q    <= chan_q;
			code_bytes_q <= lbe_pkg::encode_byte(data_byte, code_zero, code_one);
			last_q       <= last_led && (chan_q == lbe_pkg::CH_BLUE);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_led    = out_led_q;
	assign channel    = channel_q;
	assign code_bytes = code_bytes_q;
	assign last       = last_q;

endmodule

>>> sv/led_strip_blink_encoder.sv
// LED strip blink encoder.
// Input channel (in_valid / in_stall): one request per command. Force state,
// set on color, set both colors and set pattern update one LED cell and
// give no result; an index at or above LED_COUNT is dropped.
// A tick request makes every cell decide on/off, advance its blink timer if
// it is blinking and latch its chosen color; the colors then march down the
// cell chain toward the encoder, one LED per three results.
// Output channel (out_valid / out_stall): a tick gives 3 * LED_COUNT results
// (green, red, blue per LED, LED 0 first), last set on the final one. The
// first result shows once the encoder has turned busy and loaded it into the
// output register; with no stall the results follow one per cycle, paced by
// the single output register.
// in_stall stays high while a tick is being sent out and drops once the final
// result has been loaded into the output register.
// A stalled result holds its value; sending pauses until out_stall drops.
// Config port (cfg_valid / cfg_ready): index 0 sets the code byte for a zero
// bit, index 1 for a one bit; always ready. Write it only while idle.
// Reset clears all timers and times, sets on colors to blue, off colors to
// black, and the code bytes to 0xFC and 0xE0.
module led_strip_blink_encoder #(
	parameter int LED_COUNT = lbe_pkg::LED_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        opcode,
	input  logic [7:0]                        led_index,
	input  logic                              on_flag,
	input  logic [23:0]                       on_color,
	input  logic [23:0]                       off_color,
	input  logic [7:0]                        on_ticks,
	input  logic [7:0]                        off_ticks,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [3:0]                        out_led,
	output logic [1:0]                        channel,
	output logic [63:0]                       code_bytes,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                        cfg_data
);

	logic                         busy;
	logic                         accept;
	logic                         tick;
	logic                         shift;
	lbe_pkg::cmd_t                cmd;
	logic [7:0]                   code_zero_q;
	logic [7:0]                   code_one_q;
	logic [lbe_pkg::COLOR_W-1:0]  colors [LED_COUNT];

	assign in_stall  = busy;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !busy;

	always_comb begin
		cmd.op        = lbe_pkg::op_t'(opcode);
		cmd.on_flag   = on_flag;
		cmd.on_color  = on_color;
		cmd.off_color = off_color;
		cmd.on_ticks  = on_ticks;
		cmd.off_ticks = off_ticks;
		tick          = accept && (cmd.op == lbe_pkg::OP_TICK);
	end

	// code byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_zero_q <= lbe_pkg::CODE_ZERO_RST;
			code_one_q  <= lbe_pkg::CODE_ONE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				lbe_pkg::CFG_CODE_ZERO: code_zero_q <= cfg_data;
				lbe_pkg::CFG_CODE_ONE:  code_one_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// one cell per LED; colors advance toward cell 0 on each shift
	for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
		logic [lbe_pkg::COLOR_W-1:0] nxt_color;
		if (i == LED_COUNT - 1) begin : g_tail
			assign nxt_color = '0;
		end else begin : g_mid
			assign nxt_color = colors[i+1];
		end
		lbe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd_en   (accept && (led_index == 8'(i))),
			.cmd      (cmd),
			.tick     (tick),
			.shift    (shift),
			.shift_in (nxt_color),
			.color_q  (colors[i])
		);
	end

	lbe_encoder #(
		.LED_COUNT (LED_COUNT)
	) u_encoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (tick),
		.head_color (colors[0]),
		.code_zero  (code_zero_q),
		.code_one   (code_one_q),
		.out_stall  (out_stall),
		.busy_q     (busy),
		.shift      (shift),
		.out_valid  (out_valid),
		.out_led    (out_led),
		.channel    (channel),
		.code_bytes (code_bytes),
		.last       (last)
	);

endmodule
